// ===== hw/rtl/rdsge_pkg.sv =====
package rdsge_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned CHK_W = 10;
  localparam int unsigned BLOCK_W = WORD_W + CHK_W;
  localparam int unsigned DC_W = 17;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W = 80;
  localparam int unsigned OUT_DATA_W = 4 * BLOCK_W;

  localparam logic [CHK_W-1:0] OFS_A = 10'h0FC;
  localparam logic [CHK_W-1:0] OFS_B = 10'h198;
  localparam logic [CHK_W-1:0] OFS_C = 10'h168;
  localparam logic [CHK_W-1:0] OFS_CP = 10'h350;
  localparam logic [CHK_W-1:0] OFS_D = 10'h1B4;

  localparam logic [10:0] YEAR_MUL = 11'd1461;
  localparam logic [12:0] YEAR_BASE = 13'd1900;
  localparam logic [DC_W-1:0] MJD_BASE = 17'd14956;

  localparam logic [3:0] GT_PS = 4'd0;
  localparam logic [3:0] GT_RT = 4'd2;
  localparam logic [3:0] GT_CT = 4'd4;

  // Checkword contribution of each data bit: x^(i+10) mod g(x).
  localparam logic [CHK_W-1:0] CRC_COL [WORD_W] = '{
    10'h1B9, 10'h372, 10'h35D, 10'h303, 10'h3BF, 10'h2C7, 10'h037, 10'h06E,
    10'h0DC, 10'h1B8, 10'h370, 10'h359, 10'h30B, 10'h3AF, 10'h2E7, 10'h077
  };

  typedef enum logic [1:0] {
    OP_PS = 2'd0,
    OP_RT = 2'd1,
    OP_CT = 2'd2
  } op_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PI  = 3'd0,
    REG_TP  = 3'd1,
    REG_PTY = 3'd2,
    REG_TA  = 3'd3,
    REG_MS  = 3'd4,
    REG_DI  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] pi_code;
    logic        tp;
    logic [4:0]  pty;
    logic        ta;
    logic        ms;
    logic        di;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  segment;
    logic        ab_flag;
    logic [31:0] text_word;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  utc_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  segment;
    logic        ab_flag;
    logic [31:0] text_word;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  utc_offset;
  } fld_t;

  typedef struct packed {
    logic [WORD_W-1:0] wb;
    logic [WORD_W-1:0] wc;
    logic [WORD_W-1:0] wd;
    logic [CHK_W-1:0]  oc;
  } words_t;

  function automatic logic [8:0] month_term(input logic [4:0] m);
    logic [8:0] t;
    case (m)
      5'd1:    t = 9'd30;
      5'd2:    t = 9'd61;
      5'd3:    t = 9'd91;
      5'd4:    t = 9'd122;
      5'd5:    t = 9'd153;
      5'd6:    t = 9'd183;
      5'd7:    t = 9'd214;
      5'd8:    t = 9'd244;
      5'd9:    t = 9'd275;
      5'd10:   t = 9'd306;
      5'd11:   t = 9'd336;
      5'd12:   t = 9'd367;
      5'd13:   t = 9'd397;
      5'd14:   t = 9'd428;
      5'd15:   t = 9'd459;
      5'd16:   t = 9'd489;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  function automatic logic [BLOCK_W-1:0] rds_block(input logic [WORD_W-1:0] data,
                                                    input logic [CHK_W-1:0] ofs);
    logic [CHK_W-1:0] chk;
    chk = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (data[i]) begin
        chk = chk ^ CRC_COL[i];
      end
    end
    return {data, chk ^ ofs};
  endfunction

endpackage

// ===== hw/rtl/rdsge_cfg.sv =====
module rdsge_cfg
  import rdsge_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_PI:  cfg_nxt.pi_code = cfg_wdata;
        REG_TP:  cfg_nxt.tp = cfg_wdata[0];
        REG_PTY: cfg_nxt.pty = cfg_wdata[4:0];
        REG_TA:  cfg_nxt.ta = cfg_wdata[0];
        REG_MS:  cfg_nxt.ms = cfg_wdata[0];
        REG_DI:  cfg_nxt.di = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/rdsge_pipe.sv =====
module rdsge_pipe
  import rdsge_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   req_valid,
  output logic   req_ready,
  input  req_t   req,
  output logic   words_valid,
  input  logic   words_ready,
  output words_t words
);

  typedef struct packed {
    fld_t        f;
    logic [4:0]  day;
    logic        yneg;
    logic [11:0] yabs;
    logic [8:0]  mt;
  } s1_t;

  typedef struct packed {
    fld_t            f;
    logic            yneg;
    logic [DC_W-1:0] q;
    logic [DC_W-1:0] base;
  } s2_t;

  logic   v1_r, v2_r, v3_r;
  logic   rdy1, rdy2, rdy3;
  logic   op_ok;
  s1_t    s1_r, s1_nxt;
  s2_t    s2_r, s2_nxt;
  words_t s3_r, s3_nxt;

  logic        leap;
  logic [12:0] y_full;
  logic [4:0]  m_idx;
  logic [22:0] prod;
  logic [DC_W-1:0] dc;
  logic [5:0]  common;

  assign rdy3 = !v3_r || words_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign req_ready = rdy1;
  assign op_ok = (req.operation == OP_PS) || (req.operation == OP_RT) ||
                 (req.operation == OP_CT);

  always_comb begin
    leap = (req.month == 4'd1) || (req.month == 4'd2);
    y_full = {1'b0, req.year} - YEAR_BASE - {12'd0, leap};
    m_idx = {1'b0, req.month} + 5'd1 + (leap ? 5'd12 : 5'd0);
    s1_nxt.f.operation = req.operation;
    s1_nxt.f.segment = req.segment;
    s1_nxt.f.ab_flag = req.ab_flag;
    s1_nxt.f.text_word = req.text_word;
    s1_nxt.f.hour = req.hour;
    s1_nxt.f.minute = req.minute;
    s1_nxt.f.utc_offset = req.utc_offset;
    s1_nxt.day = req.day;
    s1_nxt.yneg = y_full[12];
    s1_nxt.yabs = y_full[12] ? 12'(13'd0 - y_full) : y_full[11:0];
    s1_nxt.mt = month_term(m_idx);
  end

  always_comb begin
    prod = 23'(s1_r.yabs) * 23'(YEAR_MUL);
    s2_nxt.f = s1_r.f;
    s2_nxt.yneg = s1_r.yneg;
    s2_nxt.q = prod[18:2];
    s2_nxt.base = MJD_BASE + DC_W'(s1_r.day) + DC_W'(s1_r.mt);
  end

  always_comb begin
    dc = s2_r.base + (s2_r.q ^ {DC_W{s2_r.yneg}}) + DC_W'(s2_r.yneg);
    common = {cfg.tp, cfg.pty};
    s3_nxt.oc = OFS_C;
    case (s2_r.f.operation)
      OP_PS: begin
        s3_nxt.wb = {GT_PS, 1'b1, common, cfg.ta, cfg.ms, cfg.di,
                     s2_r.f.segment[1:0]};
        s3_nxt.wc = cfg.pi_code;
        s3_nxt.wd = s2_r.f.text_word[31:16];
        s3_nxt.oc = OFS_CP;
      end
      OP_RT: begin
        s3_nxt.wb = {GT_RT, 1'b0, common, s2_r.f.ab_flag, s2_r.f.segment};
        s3_nxt.wc = s2_r.f.text_word[31:16];
        s3_nxt.wd = s2_r.f.text_word[15:0];
      end
      OP_CT: begin
        s3_nxt.wb = {GT_CT, 1'b0, common, 3'd0, dc[16:15]};
        s3_nxt.wc = {dc[14:0], s2_r.f.hour[4]};
        s3_nxt.wd = {s2_r.f.hour[3:0], s2_r.f.minute, s2_r.f.utc_offset};
      end
      default: begin
        s3_nxt.wb = '0;
        s3_nxt.wc = '0;
        s3_nxt.wd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= req_valid && op_ok;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= s1_nxt;
    end
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
    if (rdy3) begin
      s3_r <= s3_nxt;
    end
  end

  assign words_valid = v3_r;
  assign words = s3_r;

  a_drop_unused_op: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready && !op_ok |=> !v1_r)
    else $error("unused operation code entered the pipeline");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(s1_r))
    else $error("stage one lost or changed a stalled transaction");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !rdy3 |=> v2_r && $stable(s2_r))
    else $error("stage two lost or changed a stalled transaction");

endmodule

// ===== hw/rtl/rdsge_out.sv =====
module rdsge_out
  import rdsge_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [WORD_W-1:0]     pi_code,
  input  logic                  words_valid,
  output logic                  words_ready,
  input  words_t                words,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  ov_r;
  logic [OUT_DATA_W-1:0] od_r, od_nxt;

  assign words_ready = !ov_r || out_tready;

  always_comb begin
    od_nxt = {rds_block(words.wd, OFS_D), rds_block(words.wc, words.oc),
              rds_block(words.wb, OFS_B), rds_block(pi_code, OFS_A)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (words_ready) begin
      ov_r <= words_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (words_ready) begin
      od_r <= od_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    words_valid && words_ready |=> out_tvalid)
    else $error("accepted words did not reach the output register");

  a_checkword_a: assert property (@(posedge clk) disable iff (!rst_n)
    words_valid && words_ready |=> out_tdata[BLOCK_W-1:CHK_W] == $past(pi_code))
    else $error("block A data word does not match the station code");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> words_ready)
    else $error("empty output register refused new words");

endmodule

// ===== hw/rtl/rds_group_encoder_top.sv =====
// Throughput: one group per cycle; the three-stage pipeline and output register
// accept a new transaction in every cycle that the output is not stalled.
// Operation code 3 is dropped at the input and produces no output transaction.
// Reset (synchronous, active low) empties the pipeline and clears the configuration to 0.
module rds_group_encoder_top
  import rdsge_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // segment, ab_flag, text_word, year, month, day, hour, minute, utc_offset
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // block_a, block_b, block_c, block_d
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cfg_t   cfg;
  req_t   req;
  logic   words_valid;
  logic   words_ready;
  words_t words;

  always_comb begin
    req.operation = in_tuser;
    req.segment = in_tdata[3:0];
    req.ab_flag = in_tdata[4];
    req.text_word = in_tdata[36:5];
    req.year = in_tdata[48:37];
    req.month = in_tdata[52:49];
    req.day = in_tdata[57:53];
    req.hour = in_tdata[62:58];
    req.minute = in_tdata[68:63];
    req.utc_offset = in_tdata[74:69];
  end

  rdsge_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  rdsge_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req        (req),
    .words_valid(words_valid),
    .words_ready(words_ready),
    .words      (words)
  );

  rdsge_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .pi_code    (cfg.pi_code),
    .words_valid(words_valid),
    .words_ready(words_ready),
    .words      (words),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rdsge_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CHK_W-1:0] GEN_TAPS = 10'h1B9;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int GROUPS_PER_PHASE = 250;
  localparam int N_PHASES = 8;
  localparam int N_DIRECTED = 20;

  typedef logic [OUT_DATA_W-1:0] group_blocks_t;

  typedef struct {
    req_t          req;
    bit            typed;
    group_blocks_t blocks;
  } stim_row_t;

  typedef enum int {CFG_ZERO, CFG_FULL, CFG_RANDOM} cfg_mode_e;

  // A blank radio-text group with every register at its reset value.
  localparam group_blocks_t BLANK_RT_GROUP = {
    {16'h0000, 10'h1B4}, {16'h0000, 10'h168}, {16'h2000, 10'h237}, {16'h0000, 10'h0FC}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  cfg_t          station_cfg = '0;
  group_blocks_t pending_groups [$];
  req_t          offer = '0;
  bit            offer_typed = 1'b0;
  group_blocks_t offer_blocks = '0;
  int            errors = 0;
  int            idle_cycles = 0;
  int            op_count [4] = '{default: 0};
  int            tx_gap_pct = 0;
  int            rx_stall_pct = 0;
  bit            hold_req = 1'b0;
  string         block_name [4] = '{"block_a", "block_b", "block_c", "block_d"};

  always #10 clk = ~clk;

  rds_group_encoder_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  function automatic logic [CHK_W-1:0] checkword(input logic [WORD_W-1:0] data);
    logic [CHK_W-1:0] r;
    logic             fb;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      fb = data[i] ^ r[CHK_W-1];
      r = {r[CHK_W-2:0], 1'b0} ^ (fb ? GEN_TAPS : '0);
    end
    return r;
  endfunction

  function automatic logic [BLOCK_W-1:0] seal(input logic [WORD_W-1:0] w,
                                              input logic [CHK_W-1:0] ofs);
    return {w, checkword(w) ^ ofs};
  endfunction

  // Modified Julian day, with the year term truncated toward zero as in the
  // integer form of the broadcast formula.
  function automatic logic [DC_W-1:0] mjd_code(input logic [11:0] year,
                                               input logic [3:0] month,
                                               input logic [4:0] day);
    int early;
    int y;
    int m;
    int total;
    early = (month == 4'd1 || month == 4'd2) ? 1 : 0;
    y = int'(year) - 1900 - early;
    m = int'(month) + 1 + 12 * early;
    total = 14956 + int'(day) + (y * 1461) / 4 + (m * 306001) / 10000;
    return total[DC_W-1:0];
  endfunction

  function automatic group_blocks_t encode_group(input req_t g, input cfg_t c);
    logic [WORD_W-1:0] wb;
    logic [WORD_W-1:0] wc;
    logic [WORD_W-1:0] wd;
    logic [CHK_W-1:0]  oc;
    logic [DC_W-1:0]   dc;
    case (g.operation)
      OP_PS: begin
        wb = {GT_PS, 1'b1, c.tp, c.pty, c.ta, c.ms, c.di, g.segment[1:0]};
        wc = c.pi_code;
        wd = g.text_word[31:16];
        oc = OFS_CP;
      end
      OP_RT: begin
        wb = {GT_RT, 1'b0, c.tp, c.pty, g.ab_flag, g.segment};
        wc = g.text_word[31:16];
        wd = g.text_word[15:0];
        oc = OFS_C;
      end
      default: begin
        dc = mjd_code(g.year, g.month, g.day);
        wb = {GT_CT, 1'b0, c.tp, c.pty, 3'b000, dc[16:15]};
        wc = {dc[14:0], g.hour[4]};
        wd = {g.hour[3:0], g.minute, g.utc_offset};
        oc = OFS_C;
      end
    endcase
    return {seal(wd, OFS_D), seal(wc, oc), seal(wb, OFS_B), seal(c.pi_code, OFS_A)};
  endfunction

  function automatic req_t mk_req(input logic [1:0] op, input logic [3:0] seg,
                                  input logic ab, input logic [31:0] text,
                                  input logic [11:0] year, input logic [3:0] month,
                                  input logic [4:0] day, input logic [4:0] hour,
                                  input logic [5:0] minute, input logic [5:0] lofs);
    req_t g;
    g.operation = op;
    g.segment = seg;
    g.ab_flag = ab;
    g.text_word = text;
    g.year = year;
    g.month = month;
    g.day = day;
    g.hour = hour;
    g.minute = minute;
    g.utc_offset = lofs;
    return g;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic drive_group(input req_t g, input bit typed, input group_blocks_t blocks);
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, g.utc_offset, g.minute, g.hour, g.day, g.month, g.year,
                 g.text_word, g.ab_flag, g.segment};
    in_tuser <= g.operation;
    offer <= g;
    offer_typed <= typed;
    offer_blocks <= blocks;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_groups.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_PI:  station_cfg.pi_code = value;
      REG_TP:  station_cfg.tp = value[0];
      REG_PTY: station_cfg.pty = value[4:0];
      REG_TA:  station_cfg.ta = value[0];
      REG_MS:  station_cfg.ms = value[0];
      REG_DI:  station_cfg.di = value[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input cfg_mode_e mode);
    reg_idx_e regs [6];
    regs = '{REG_PI, REG_TP, REG_PTY, REG_TA, REG_MS, REG_DI};
    for (int k = 0; k < 6; k++) begin
      case (mode)
        CFG_ZERO: write_reg(regs[k], '0);
        CFG_FULL: write_reg(regs[k], '1);
        default:  write_reg(regs[k], CFG_DATA_W'($urandom));
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    group_blocks_t want;
    if (rst_n && in_tvalid && in_tready) begin
      op_count[offer.operation]++;
      if (offer.operation != OP_UNUSED) begin
        pending_groups.push_back(offer_typed ? offer_blocks : encode_group(offer, station_cfg));
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_groups.size() == 0) begin
        report_error($sformatf("unexpected group %h", out_tdata));
      end else begin
        want = pending_groups.pop_front();
        for (int b = 0; b < 4; b++) begin
          if (out_tdata[b*BLOCK_W +: BLOCK_W] !== want[b*BLOCK_W +: BLOCK_W]) begin
            report_error($sformatf("%s is %h, expected %h", block_name[b],
                                   out_tdata[b*BLOCK_W +: BLOCK_W],
                                   want[b*BLOCK_W +: BLOCK_W]));
          end
        end
      end
    end
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    stim_row_t directed_table [N_DIRECTED];
    req_t      g;
    bit        wild;
    bit        quiet;
    int        sent;

    directed_table[0]  = '{mk_req(OP_RT, 4'd0, 1'b0, 32'h0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0,
                                  6'd0), 1'b1, BLANK_RT_GROUP};
    directed_table[1]  = '{mk_req(OP_PS, 4'd0, 1'b0, 32'h0, 12'd0, 4'd0, 5'd0, 5'd0, 6'd0,
                                  6'd0), 1'b0, '0};
    directed_table[2]  = '{mk_req(OP_PS, 4'hF, 1'b1, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 5'h1F,
                                  5'h1F, 6'h3F, 6'h3F), 1'b0, '0};
    directed_table[3]  = '{mk_req(OP_PS, 4'd2, 1'b0, 32'h0000_FFFF, 12'd2000, 4'd6, 5'd1,
                                  5'd1, 6'd1, 6'd1), 1'b0, '0};
    directed_table[4]  = '{mk_req(OP_PS, 4'd3, 1'b0, 32'h4142_4344, 12'd0, 4'd0, 5'd0, 5'd0,
                                  6'd0, 6'd0), 1'b0, '0};
    directed_table[5]  = '{mk_req(OP_RT, 4'hF, 1'b1, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 5'h1F,
                                  5'h1F, 6'h3F, 6'h3F), 1'b0, '0};
    directed_table[6]  = '{mk_req(OP_RT, 4'd5, 1'b0, 32'h8080_8080, 12'd0, 4'd0, 5'd0, 5'd0,
                                  6'd0, 6'd0), 1'b0, '0};
    directed_table[7]  = '{mk_req(OP_RT, 4'd10, 1'b1, 32'hDEAD_BEEF, 12'd0, 4'd0, 5'd0, 5'd0,
                                  6'd0, 6'd0), 1'b0, '0};
    directed_table[8]  = '{mk_req(OP_CT, 4'd0, 1'b0, 32'h0, 12'd2099, 4'd12, 5'd31, 5'd23,
                                  6'd59, 6'sd24), 1'b0, '0};
    directed_table[9]  = '{mk_req(OP_CT, 4'd0, 1'b0, 32'h0, 12'd1901, 4'd1, 5'd1, 5'd0,
                                  6'd0, -6'sd24), 1'b0, '0};
    directed_table[10] = '{mk_req(OP_CT, 4'd0, 1'b0, 32'h0, 12'd1900, 4'd2, 5'd28, 5'd12,
                                  6'd30, 6'd0), 1'b0, '0};
    directed_table[11] = '{mk_req(OP_CT, 4'd0, 1'b0, 32'h0, 12'd1899, 4'd3, 5'd1, 5'd6,
                                  6'd15, 6'd2), 1'b0, '0};
    directed_table[12] = '{mk_req(OP_CT, 4'd0, 1'b0, 32'h0, 12'd0, 4'd1, 5'd1, 5'd0,
                                  6'd0, 6'd0), 1'b0, '0};
    directed_table[13] = '{mk_req(OP_CT, 4'hF, 1'b1, 32'hFFFF_FFFF, 12'hFFF, 4'd15, 5'd31,
                                  5'd31, 6'd63, 6'h3F), 1'b0, '0};
    directed_table[14] = '{mk_req(OP_CT, 4'd0, 1'b0, 32'h0, 12'd2024, 4'd0, 5'd15, 5'd12,
                                  6'd30, 6'd0), 1'b0, '0};
    directed_table[15] = '{mk_req(OP_CT, 4'd0, 1'b0, 32'h0, 12'd2024, 4'd13, 5'd0, 5'd24,
                                  6'd60, 6'h20), 1'b0, '0};
    directed_table[16] = '{mk_req(OP_CT, 4'd0, 1'b0, 32'h0, 12'd2000, 4'd2, 5'd29, 5'd16,
                                  6'd0, 6'h1F), 1'b0, '0};
    directed_table[17] = '{mk_req(OP_CT, 4'd0, 1'b0, 32'h0, 12'd1858, 4'd11, 5'd17, 5'd8,
                                  6'd45, -6'sd1), 1'b0, '0};
    directed_table[18] = '{mk_req(OP_UNUSED, 4'hF, 1'b1, 32'hFFFF_FFFF, 12'hFFF, 4'hF, 5'h1F,
                                  5'h1F, 6'h3F, 6'h3F), 1'b0, '0};
    directed_table[19] = '{mk_req(OP_UNUSED, 4'd0, 1'b0, 32'h0, 12'd0, 4'd0, 5'd0, 5'd0,
                                  6'd0, 6'd0), 1'b0, '0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_gap_pct = 20;
    rx_stall_pct = 20;
    for (int r = 0; r < N_DIRECTED; r++) begin
      drive_group(directed_table[r].req, directed_table[r].typed, directed_table[r].blocks);
    end
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      load_config(p == 0 ? CFG_FULL : (p == 1 ? CFG_ZERO : CFG_RANDOM));
      quiet = (p == N_PHASES - 1) || (p == 3);
      tx_gap_pct = quiet ? 0 : 10 * $urandom_range(1, 5);
      rx_stall_pct = quiet ? 0 : 10 * $urandom_range(1, 5);
      if (p == 2) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < GROUPS_PER_PHASE) begin
        g.operation = ($urandom_range(99) < 6) ? OP_UNUSED : 2'($urandom_range(0, 2));
        g.segment = 4'($urandom);
        g.ab_flag = 1'($urandom);
        g.text_word = $urandom;
        wild = ($urandom_range(99) < 15);
        g.year = wild ? 12'($urandom) : 12'($urandom_range(1901, 2099));
        g.month = wild ? 4'($urandom) : 4'($urandom_range(1, 12));
        g.day = wild ? 5'($urandom) : 5'($urandom_range(1, 31));
        g.hour = wild ? 5'($urandom) : 5'($urandom_range(0, 23));
        g.minute = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
        g.utc_offset = wild ? 6'($urandom) : 6'(int'($urandom_range(0, 48)) - 24);
        drive_group(g, 1'b0, '0);
        if (g.operation != OP_UNUSED) begin
          sent++;
        end
      end
      settle();
    end

    if (pending_groups.size() != 0) begin
      report_error($sformatf("%0d groups never arrived", pending_groups.size()));
    end
    $display("Covered %0d station-name, %0d radio-text and %0d clock-time groups, plus %0d",
             op_count[OP_PS], op_count[OP_RT], op_count[OP_CT], op_count[OP_UNUSED]);
    $display("unused requests, over %0d register settings and a %0d-cycle output hold-off.",
             N_PHASES + 1, HOLD_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
